FILE: hw/rtl/cscg_pkg.sv
// Shared types, constants and helpers for the cubic spline coefficient generator.
// Used by cscg_dp, cscg_ctrl and the top level; no dependencies.
`default_nettype none

package cscg_pkg;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int MAX_POINTS_DEF   = 4096;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 32;
	localparam int NP_W   = 13;
	localparam int NC_W   = 5;
	localparam int S_W    = 50;

	localparam logic [NP_W-1:0]   NP_RESET  = 13'd2;
	localparam logic [NC_W-1:0]   NC_RESET  = 5'd1;
	localparam logic [CFG_DW-1:0] INV_RESET = 32'h0001_0000;

	localparam logic [CFG_IW-1:0] CFG_NUM_POINTS   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_NUM_CHANNELS = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_INV_SPACING  = 2'd2;

	typedef enum logic [2:0] {
		OP_SLOPE_FIRST = 3'd0,
		OP_SLOPE_CTR   = 3'd1,
		OP_SLOPE_BACK  = 3'd2,
		OP_S           = 3'd3,
		OP_C2          = 3'd4,
		OP_INNER       = 3'd5,
		OP_C3          = 3'd6
	} op_t;

	typedef enum logic {
		KIND_MID  = 1'b0,
		KIND_LAST = 1'b1
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  start;
		op_t   op;
		kind_t kind;
		logic  publish;
		logic  commit;
		logic  upd_slope;
		logic  last_run;
		logic  last_table;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} sts_t;

	function automatic int idx_w(input int n);
		idx_w = (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cscg_mulsc.sv
// Scaled multiply unit: round(a * b / 2^16 or 2^17), ties away from zero, capped at 2^62.
// One 32x32 multiplier used over two passes; needs nothing from the package.
`default_nettype none

module cscg_mulsc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic        [31:0] b,
	input  logic               sh17,
	output logic               done,
	output logic signed [63:0] res
);

	localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;

	logic        [3:0]  ph_q;
	logic               done_q;
	logic        [63:0] mag_q;
	logic               neg_q;
	logic        [31:0] b_q;
	logic               sh17_q;
	logic        [63:0] prod_q;
	logic        [95:0] acc_q;
	logic signed [63:0] res_q;
	logic        [96:0] sum;
	logic        [80:0] shr;
	logic        [63:0] rmag;

	always_comb begin
		sum  = {1'b0, acc_q} + (sh17_q ? 97'h1_0000 : 97'h0_8000);
		shr  = sh17_q ? {1'b0, sum[96:17]} : sum[96:16];
		rmag = (shr > 81'(CAP)) ? CAP : shr[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= start ? 4'b0001 : {ph_q[2:0], 1'b0};
			done_q <= ph_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= a[63];
			mag_q  <= a[63] ? $unsigned(-a) : $unsigned(a);
			b_q    <= b;
			sh17_q <= sh17;
		end
		if (ph_q[0]) begin
			prod_q <= mag_q[31:0] * b_q;
		end
		if (ph_q[1]) begin
			acc_q  <= {32'd0, prod_q};
			prod_q <= mag_q[63:32] * b_q;
		end
		if (ph_q[2]) begin
			acc_q <= acc_q + {prod_q, 32'd0};
		end
		if (ph_q[3]) begin
			res_q <= neg_q ? -$signed(rmag) : $signed(rmag);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cscg_dp.sv
// Datapath: per-channel sample and slope stores, operand selection, coefficient
// registers and the output register. Uses cscg_pkg and instantiates cscg_mulsc.
`default_nettype none

module cscg_dp #(
	parameter int MAX_CHANNELS = cscg_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_POINTS   = cscg_pkg::MAX_POINTS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_write,
	input  logic [cscg_pkg::CFG_IW-1:0]                 cfg_index,
	input  logic [cscg_pkg::CFG_DW-1:0]                 cfg_data,
	input  cscg_pkg::cmd_t                              cmd,
	input  logic [cscg_pkg::idx_w(MAX_CHANNELS)-1:0]    addr,
	input  logic [cscg_pkg::idx_w(MAX_POINTS-1)-1:0]    interval,
	output cscg_pkg::sts_t                              sts,
	input  logic signed [31:0]                          sample,
	output logic                                        coef_valid,
	input  logic                                        coef_ready,
	output logic [cscg_pkg::idx_w(MAX_POINTS-1)-1:0]    interval_index,
	output logic [cscg_pkg::idx_w(MAX_CHANNELS)-1:0]    channel_index,
	output logic signed [31:0]                          coef_value,
	output logic signed [31:0]                          coef_linear,
	output logic signed [31:0]                          coef_quadratic,
	output logic signed [31:0]                          coef_cubic,
	output logic                                        saturated,
	output logic                                        last_of_run,
	output logic                                        last_of_table
);

	localparam int CW = cscg_pkg::idx_w(MAX_CHANNELS);
	localparam int IW = cscg_pkg::idx_w(MAX_POINTS - 1);
	localparam int SW = cscg_pkg::S_W;

	logic [31:0] prior_mem [MAX_CHANNELS];
	logic [31:0] older_mem [MAX_CHANNELS];
	logic [32:0] slope_mem [MAX_CHANNELS];

	logic [31:0]        inv_q;
	logic signed [31:0] y_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] old_q;
	logic signed [31:0] slope_rd_q;
	logic               clip_rd_q;
	logic signed [31:0] m_q;
	logic               mclip_q;
	logic signed [31:0] mb_q;
	logic signed [SW-1:0] s_q;
	logic signed [63:0] inner_q;
	logic signed [31:0] c2_q;
	logic               c2clip_q;
	logic signed [31:0] c3_q;
	logic               c3clip_q;

	logic               valid_q;
	logic [IW-1:0]      iv_q;
	logic [CW-1:0]      ch_q;
	logic signed [31:0] value_q;
	logic signed [31:0] linear_q;
	logic signed [31:0] quad_q;
	logic signed [31:0] cubic_q;
	logic               sat_q;
	logic               run_q;
	logic               table_q;

	logic signed [31:0] y0;
	logic signed [31:0] y1;
	logic signed [31:0] m0;
	logic               m0clip;
	logic signed [31:0] m1;
	logic signed [63:0] s64;
	logic signed [63:0] m0_64;
	logic signed [63:0] m1_64;
	logic signed [63:0] u;
	logic signed [63:0] w;
	logic signed [63:0] op_a;
	logic               op_sh17;
	logic               u_done;
	logic signed [63:0] u_res;
	logic [32:0]        u_sat;

	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic fits;
		fits  = (v[63:31] == {33{v[63]}});
		sat32 = fits ? {1'b0, v[31:0]} : {1'b1, v[63] ? 32'h8000_0000 : 32'h7fff_ffff};
	endfunction

	always_comb begin
		if (cmd.kind == cscg_pkg::KIND_MID) begin
			y0     = old_q;
			y1     = prev_q;
			m0     = slope_rd_q;
			m0clip = clip_rd_q;
			m1     = m_q;
		end else begin
			y0     = prev_q;
			y1     = y_q;
			m0     = m_q;
			m0clip = mclip_q;
			m1     = mb_q;
		end
		s64   = 64'(s_q);
		m0_64 = 64'(m0);
		m1_64 = 64'(m1);
		u     = s64 + (s64 <<< 1) - (m0_64 <<< 1) - m1_64;
		w     = m0_64 + m1_64 - (s64 <<< 1);
		op_sh17 = 1'b0;
		unique case (cmd.op) inside
			cscg_pkg::OP_SLOPE_FIRST, cscg_pkg::OP_SLOPE_BACK: op_a = 64'(y_q) - 64'(prev_q);
			cscg_pkg::OP_SLOPE_CTR: begin
				op_a    = 64'(y_q) - 64'(old_q);
				op_sh17 = 1'b1;
			end
			cscg_pkg::OP_S:     op_a = 64'(y1) - 64'(y0);
			cscg_pkg::OP_C2:    op_a = u;
			cscg_pkg::OP_INNER: op_a = w;
			cscg_pkg::OP_C3:    op_a = inner_q;
			default:            op_a = '0;
		endcase
	end

	cscg_mulsc u_mulsc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (op_a),
		.b      (inv_q),
		.sh17   (op_sh17),
		.done   (u_done),
		.res    (u_res)
	);

	assign u_sat = sat32(u_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q   <= cscg_pkg::INV_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == cscg_pkg::CFG_INV_SPACING) begin
				inv_q <= cfg_data;
			end
			if (cmd.publish) begin
				valid_q <= 1'b1;
			end else if (coef_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q                     <= sample;
			prev_q                  <= prior_mem[addr];
			old_q                   <= older_mem[addr];
			{clip_rd_q, slope_rd_q} <= slope_mem[addr];
		end
		if (cmd.commit) begin
			prior_mem[addr] <= y_q;
			if (cmd.upd_slope) begin
				older_mem[addr] <= prev_q;
				slope_mem[addr] <= {mclip_q, m_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (u_done) begin
			unique case (cmd.op)
				cscg_pkg::OP_SLOPE_FIRST: begin
					{mclip_q, m_q} <= u_sat;
					mb_q           <= u_sat[31:0];
				end
				cscg_pkg::OP_SLOPE_CTR:  {mclip_q, m_q} <= u_sat;
				cscg_pkg::OP_SLOPE_BACK: mb_q <= u_sat[31:0];
				cscg_pkg::OP_S:          s_q <= u_res[SW-1:0];
				cscg_pkg::OP_C2:         {c2clip_q, c2_q} <= u_sat;
				cscg_pkg::OP_INNER:      inner_q <= u_res;
				cscg_pkg::OP_C3:         {c3clip_q, c3_q} <= u_sat;
				default: ;
			endcase
		end
		if (cmd.publish) begin
			iv_q     <= interval;
			ch_q     <= addr;
			value_q  <= y0;
			linear_q <= m0;
			quad_q   <= c2_q;
			cubic_q  <= c3_q;
			sat_q    <= m0clip | c2clip_q | c3clip_q;
			run_q    <= cmd.last_run;
			table_q  <= cmd.last_table;
		end
	end

	assign sts.done     = u_done;
	assign sts.out_free = !valid_q || coef_ready;

	assign coef_valid     = valid_q;
	assign interval_index = iv_q;
	assign channel_index  = ch_q;
	assign coef_value     = value_q;
	assign coef_linear    = linear_q;
	assign coef_quadratic = quad_q;
	assign coef_cubic     = cubic_q;
	assign saturated      = sat_q;
	assign last_of_run    = run_q;
	assign last_of_table  = table_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cscg_ctrl.sv
// Controller: table geometry registers, row and channel counters, and the
// sequencer that issues scaled-multiply operations. Uses cscg_pkg.
`default_nettype none

module cscg_ctrl #(
	parameter int MAX_CHANNELS = cscg_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_POINTS   = cscg_pkg::MAX_POINTS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [cscg_pkg::CFG_IW-1:0]              cfg_index,
	input  logic [cscg_pkg::CFG_DW-1:0]              cfg_data,
	input  logic                                     sample_valid,
	output logic                                     sample_ready,
	input  cscg_pkg::sts_t                           sts,
	output cscg_pkg::cmd_t                           cmd,
	output logic [cscg_pkg::idx_w(MAX_CHANNELS)-1:0] addr,
	output logic [cscg_pkg::idx_w(MAX_POINTS-1)-1:0] interval
);

	localparam int CW = cscg_pkg::idx_w(MAX_CHANNELS);
	localparam int RW = cscg_pkg::idx_w(MAX_POINTS);
	localparam int IW = cscg_pkg::idx_w(MAX_POINTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ISSUE  = 5'b00010,
		ST_WAIT   = 5'b00100,
		ST_PUB    = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t                      state_q;
	state_t                      state_d;
	cscg_pkg::op_t               op_q;
	cscg_pkg::op_t               op_d;
	cscg_pkg::kind_t             kind_q;
	cscg_pkg::kind_t             kind_d;
	logic [RW-1:0]               row_q;
	logic [CW-1:0]               ch_q;
	logic [cscg_pkg::NP_W-1:0]   num_points_q;
	logic [cscg_pkg::NC_W-1:0]   num_channels_q;

	logic [31:0] np;
	logic [31:0] nc;
	logic [31:0] n_eff;
	logic [31:0] nch_eff;
	logic        last_row;
	logic        last_ch;
	logic        row_zero;
	logic        row_one;
	logic        accept;
	logic        geom_write;

	always_comb begin
		np       = 32'(num_points_q);
		nc       = 32'(num_channels_q);
		n_eff    = (np < 32'd2) ? 32'd2 : ((np > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : np);
		nch_eff  = (nc < 32'd1) ? 32'd1 :
			((nc > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : nc);
		last_row = (32'(row_q) + 32'd1) >= n_eff;
		last_ch  = (32'(ch_q) + 32'd1) >= nch_eff;
		row_zero = (row_q == '0);
		row_one  = (row_q == RW'(1));
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign geom_write   = cfg_write && (cfg_index == cscg_pkg::CFG_NUM_POINTS ||
		cfg_index == cscg_pkg::CFG_NUM_CHANNELS);

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		kind_d  = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (row_zero) begin
						state_d = ST_COMMIT;
					end else begin
						state_d = ST_ISSUE;
						op_d    = row_one ? cscg_pkg::OP_SLOPE_FIRST : cscg_pkg::OP_SLOPE_CTR;
					end
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (sts.done) begin
					unique case (op_q)
						cscg_pkg::OP_SLOPE_FIRST: begin
							if (last_row) begin
								kind_d  = cscg_pkg::KIND_LAST;
								op_d    = cscg_pkg::OP_S;
								state_d = ST_ISSUE;
							end else begin
								state_d = ST_COMMIT;
							end
						end
						cscg_pkg::OP_SLOPE_CTR: begin
							kind_d  = cscg_pkg::KIND_MID;
							op_d    = cscg_pkg::OP_S;
							state_d = ST_ISSUE;
						end
						cscg_pkg::OP_SLOPE_BACK: begin
							kind_d  = cscg_pkg::KIND_LAST;
							op_d    = cscg_pkg::OP_S;
							state_d = ST_ISSUE;
						end
						cscg_pkg::OP_S: begin
							op_d    = cscg_pkg::OP_C2;
							state_d = ST_ISSUE;
						end
						cscg_pkg::OP_C2: begin
							op_d    = cscg_pkg::OP_INNER;
							state_d = ST_ISSUE;
						end
						cscg_pkg::OP_INNER: begin
							op_d    = cscg_pkg::OP_C3;
							state_d = ST_ISSUE;
						end
						cscg_pkg::OP_C3: state_d = ST_PUB;
						default:         state_d = ST_COMMIT;
					endcase
				end
			end
			ST_PUB: begin
				if (sts.out_free) begin
					if (kind_q == cscg_pkg::KIND_MID && last_row) begin
						op_d    = cscg_pkg::OP_SLOPE_BACK;
						state_d = ST_ISSUE;
					end else begin
						state_d = ST_COMMIT;
					end
				end
			end
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= cscg_pkg::OP_S;
			kind_q         <= cscg_pkg::KIND_MID;
			row_q          <= '0;
			ch_q           <= '0;
			num_points_q   <= cscg_pkg::NP_RESET;
			num_channels_q <= cscg_pkg::NC_RESET;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			kind_q  <= kind_d;
			if (geom_write) begin
				if (cfg_index == cscg_pkg::CFG_NUM_POINTS) begin
					num_points_q <= cfg_data[cscg_pkg::NP_W-1:0];
				end else begin
					num_channels_q <= cfg_data[cscg_pkg::NC_W-1:0];
				end
				row_q <= '0;
				ch_q  <= '0;
			end else if (state_q == ST_COMMIT) begin
				if (last_ch) begin
					ch_q  <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					ch_q <= ch_q + CW'(1);
				end
			end
		end
	end

	always_comb begin
		cmd.load       = accept;
		cmd.start      = (state_q == ST_ISSUE);
		cmd.op         = op_q;
		cmd.kind       = kind_q;
		cmd.publish    = (state_q == ST_PUB) && sts.out_free;
		cmd.commit     = (state_q == ST_COMMIT);
		cmd.upd_slope  = !row_zero;
		cmd.last_run   = (kind_q == cscg_pkg::KIND_LAST) || !last_row;
		cmd.last_table = (kind_q == cscg_pkg::KIND_LAST) && last_ch;
	end

	assign addr     = ch_q;
	assign interval = (kind_q == cscg_pkg::KIND_MID) ? IW'(row_q - RW'(2)) : IW'(row_q - RW'(1));

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == ST_WAIT)
		else $error("multiply result arrived outside the wait state");

	a_counters_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COMMIT) && !cfg_write |=> $stable(row_q) && $stable(ch_q))
		else $error("row or channel counter moved without a commit");

	a_table_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish && cmd.last_table |=> state_q == ST_COMMIT ##1 (row_q == '0 && ch_q == '0))
		else $error("counters did not wrap after the last interval of the table");

	a_table_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish && cmd.last_table |-> cmd.last_run)
		else $error("last interval of the table not marked as end of run");

endmodule

`default_nettype wire

FILE: hw/rtl/cubic_spline_coefficient_generator.sv
// Top level of the cubic spline coefficient generator.
// Uses cscg_pkg; instantiates cscg_ctrl and cscg_dp (which holds cscg_mulsc).
//
// Samples arrive row by row with channels interleaved, signed Q16.16; each
// request is taken only while the sequencer is idle. All products go through
// one 32x32 multiplier in a scaled-multiply unit, and each scaled product
// goes through issue, two multiplier passes, accumulate, round, capture.
// A first-row request issues no product, a second-row request without an
// interval one slope product, an interior request one slope and four
// coefficient products, and a later last-row request two intervals. Each
// publish waits until the output register is free. The output register
// lets the next request in while a result still waits.
`default_nettype none

module cubic_spline_coefficient_generator #(
	parameter int MAX_CHANNELS = cscg_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_POINTS   = cscg_pkg::MAX_POINTS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [cscg_pkg::CFG_IW-1:0]              cfg_index,
	input  logic [cscg_pkg::CFG_DW-1:0]              cfg_data,
	input  logic                                     sample_valid,
	output logic                                     sample_ready,
	input  logic signed [31:0]                       sample,
	output logic                                     coef_valid,
	input  logic                                     coef_ready,
	output logic [cscg_pkg::idx_w(MAX_POINTS-1)-1:0] interval_index,
	output logic [cscg_pkg::idx_w(MAX_CHANNELS)-1:0] channel_index,
	output logic signed [31:0]                       coef_value,
	output logic signed [31:0]                       coef_linear,
	output logic signed [31:0]                       coef_quadratic,
	output logic signed [31:0]                       coef_cubic,
	output logic                                     saturated,
	output logic                                     last_of_run,
	output logic                                     last_of_table
);

	localparam int CW = cscg_pkg::idx_w(MAX_CHANNELS);
	localparam int IW = cscg_pkg::idx_w(MAX_POINTS - 1);

	cscg_pkg::cmd_t cmd;
	cscg_pkg::sts_t sts;
	logic [CW-1:0]  addr;
	logic [IW-1:0]  interval;

	cscg_ctrl #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_POINTS   (MAX_POINTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd),
		.addr         (addr),
		.interval     (interval)
	);

	cscg_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_POINTS   (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.addr           (addr),
		.interval       (interval),
		.sts            (sts),
		.sample         (sample),
		.coef_valid     (coef_valid),
		.coef_ready     (coef_ready),
		.interval_index (interval_index),
		.channel_index  (channel_index),
		.coef_value     (coef_value),
		.coef_linear    (coef_linear),
		.coef_quadratic (coef_quadratic),
		.coef_cubic     (coef_cubic),
		.saturated      (saturated),
		.last_of_run    (last_of_run),
		.last_of_table  (last_of_table)
	);

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for cubic_spline_coefficient_generator: a directed table, then random
// tables, with every coefficient checked against a fixed-point Hermite predictor or known values.
// Depends on cscg_pkg and the RTL of the block; reads no files.

module testbench;
	import cscg_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int SETTLE = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 800;
	localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;
	localparam longint SAT_HIGH = 64'sd2147483647;
	localparam longint SAT_LOW = -64'sd2147483648;

	typedef struct {
		logic [11:0] interval;
		logic [3:0]  channel;
		logic [31:0] value, linear, quadratic, cubic;
		logic        saturated, run_end, table_end;
	} coef_t;

	typedef enum {ROW_WRITE, ROW_FEED, ROW_FEED_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CFG_IW-1:0] index;
		logic [31:0]       data;
		coef_t             want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_write;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	logic                sample_valid;
	logic                sample_ready;
	logic signed [31:0]  sample;
	logic                coef_valid;
	logic                coef_ready;
	logic [11:0]         interval_index;
	logic [3:0]          channel_index;
	logic signed [31:0]  coef_value;
	logic signed [31:0]  coef_linear;
	logic signed [31:0]  coef_quadratic;
	logic signed [31:0]  coef_cubic;
	logic                saturated;
	logic                last_of_run;
	logic                last_of_table;

	logic [NP_W-1:0] tbl_points;
	logic [NC_W-1:0] tbl_channels;
	logic [31:0]     tbl_inv;
	int              held_older [MAX_CHANNELS_DEF];
	int              held_prior [MAX_CHANNELS_DEF];
	int              held_slope [MAX_CHANNELS_DEF];
	bit              held_slope_clip [MAX_CHANNELS_DEF];
	int              tbl_row;
	int              tbl_chan;
	coef_t           step_out [2];
	int              step_count;
	coef_t           pending_coefs [$];
	coef_t           oldest;
	coef_t           no_coef;
	row_t            directed_rows [$];
	int              errors;
	int              cycles;
	bit              calm;
	int              hold_requests;
	int              hold_served;
	int              hold_left;

	cubic_spline_coefficient_generator dut (.*);

	function automatic longint scaled_product(longint a, logic [31:0] b, int sh);
		logic neg;
		longint unsigned mag, bw, hi, lo, r, cap;
		neg = a < 0;
		mag = neg ? -a : a;
		bw = b;
		hi = (mag >> 32) * bw;
		lo = (mag & 64'hFFFF_FFFF) * bw;
		cap = 64'd1 << 62;
		if (hi >= (64'd1 << (30 + sh))) begin
			r = cap;
		end else begin
			r = (hi << (32 - sh)) + (lo >> sh) + ((lo >> (sh - 1)) & 64'd1);
			if (r > cap)
				r = cap;
		end
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] clip32(longint v, inout bit clipped);
		if (v > SAT_HIGH) begin
			clipped = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < SAT_LOW) begin
			clipped = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic int table_points();
		int n;
		n = tbl_points;
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS_DEF)
			n = MAX_POINTS_DEF;
		return n;
	endfunction

	function automatic int table_channels();
		int n;
		n = tbl_channels;
		if (n < 1)
			n = 1;
		if (n > MAX_CHANNELS_DEF)
			n = MAX_CHANNELS_DEF;
		return n;
	endfunction

	function automatic coef_t hermite_interval(int interval, int ch, int y0, int y1, int m0,
			bit m0_clip, int m1);
		coef_t res;
		bit clip;
		longint s, u, w;
		clip = m0_clip;
		s = scaled_product(longint'(y1) - longint'(y0), tbl_inv, 16);
		u = 3 * s - 2 * longint'(m0) - longint'(m1);
		w = longint'(m0) + longint'(m1) - 2 * s;
		res.interval = interval[11:0];
		res.channel = ch[3:0];
		res.value = y0;
		res.linear = m0;
		res.quadratic = clip32(scaled_product(u, tbl_inv, 16), clip);
		res.cubic = clip32(scaled_product(scaled_product(w, tbl_inv, 16), tbl_inv, 16), clip);
		res.saturated = clip;
		res.run_end = 1'b0;
		res.table_end = 1'b0;
		return res;
	endfunction

	function automatic void advance_table(int y);
		int n, nch, r, ch, prev, old, m, mb;
		bit last_row, last_ch, mclip, bclip;
		n = table_points();
		nch = table_channels();
		r = tbl_row;
		ch = tbl_chan;
		last_row = r + 1 >= n;
		last_ch = ch + 1 >= nch;
		step_count = 0;
		if (r >= 1) begin
			prev = held_prior[ch];
			mclip = 1'b0;
			if (r == 1) begin
				m = clip32(scaled_product(longint'(y) - longint'(prev), tbl_inv, 16), mclip);
				if (last_row) begin
					step_out[step_count] = hermite_interval(0, ch, prev, y, m, mclip, m);
					step_count++;
				end
			end else begin
				old = held_older[ch];
				m = clip32(scaled_product(longint'(y) - longint'(old), tbl_inv, 17), mclip);
				step_out[step_count] = hermite_interval(r - 2, ch, old, prev, held_slope[ch],
					held_slope_clip[ch], m);
				step_count++;
				if (last_row) begin
					bclip = 1'b0;
					mb = clip32(scaled_product(longint'(y) - longint'(prev), tbl_inv, 16), bclip);
					step_out[step_count] = hermite_interval(r - 1, ch, prev, y, m, mclip, mb);
					step_count++;
				end
			end
			held_slope[ch] = m;
			held_slope_clip[ch] = mclip;
			held_older[ch] = prev;
		end
		held_prior[ch] = y;
		if (step_count > 0) begin
			step_out[step_count - 1].run_end = 1'b1;
			if (last_row && last_ch)
				step_out[step_count - 1].table_end = 1'b1;
		end
		if (last_ch) begin
			tbl_chan = 0;
			tbl_row = last_row ? 0 : r + 1;
		end else begin
			tbl_chan = ch + 1;
		end
	endfunction

	function automatic void apply_register(logic [CFG_IW-1:0] idx, logic [31:0] data);
		case (idx)
			CFG_NUM_POINTS: begin
				tbl_points = data[NP_W-1:0];
				tbl_row = 0;
				tbl_chan = 0;
			end
			CFG_NUM_CHANNELS: begin
				tbl_channels = data[NC_W-1:0];
				tbl_row = 0;
				tbl_chan = 0;
			end
			CFG_INV_SPACING: begin
				tbl_inv = data;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic coef_t known_interval(logic [31:0] c0, c1, c2, c3, logic sat);
		coef_t res;
		res.interval = '0;
		res.channel = '0;
		res.value = c0;
		res.linear = c1;
		res.quadratic = c2;
		res.cubic = c3;
		res.saturated = sat;
		res.run_end = 1'b1;
		res.table_end = 1'b1;
		return res;
	endfunction

	function automatic void add_write(logic [CFG_IW-1:0] idx, logic [31:0] data);
		row_t row;
		row.kind = ROW_WRITE;
		row.index = idx;
		row.data = data;
		row.want = no_coef;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_feed(logic [31:0] data);
		row_t row;
		row.kind = ROW_FEED;
		row.index = CFG_NUM_POINTS;
		row.data = data;
		row.want = no_coef;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_known(logic [31:0] data, coef_t want);
		row_t row;
		row.kind = ROW_FEED_KNOWN;
		row.index = CFG_NUM_POINTS;
		row.data = data;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// drop valid, drain every expected result, then give the block time to finish a silent request
	task automatic quiesce();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_register(logic [CFG_IW-1:0] idx, logic [31:0] data);
		quiesce();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_register(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic feed_sample(logic [31:0] data, bit known, coef_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 14) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= data;
		do @(posedge clk); while (!sample_ready);
		advance_table(data);
		if (known) begin
			pending_coefs.push_back(want);
		end else begin
			for (int k = 0; k < step_count; k++)
				pending_coefs.push_back(step_out[k]);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %h, got %h", name, want, seen);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && coef_valid && coef_ready) begin
			if (pending_coefs.size() == 0) begin
				$error("result with nothing pending: interval %0d channel %0d",
					interval_index, channel_index);
				errors++;
			end else begin
				oldest = pending_coefs.pop_front();
				check_field("interval_index", oldest.interval, interval_index);
				check_field("channel_index", oldest.channel, channel_index);
				check_field("coef_value", oldest.value, coef_value);
				check_field("coef_linear", oldest.linear, coef_linear);
				check_field("coef_quadratic", oldest.quadratic, coef_quadratic);
				check_field("coef_cubic", oldest.cubic, coef_cubic);
				check_field("saturated", oldest.saturated, saturated);
				check_field("last_of_run", oldest.run_end, last_of_run);
				check_field("last_of_table", oldest.table_end, last_of_table);
			end
		end
	end

	// hold off for a long stretch whenever the sender asks, else stall at random outside calm stretches
	initial begin
		coef_ready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				coef_ready <= 1'b0;
			end else begin
				coef_ready <= calm || $urandom_range(99) >= 14;
			end
		end
	end

	initial begin
		int fed, pts, chans, items, mid;
		logic [31:0] inv, pts_w, ch_w, value;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_NUM_POINTS;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		calm = 1'b0;
		errors = 0;
		cycles = 0;
		hold_requests = 0;
		tbl_points = NP_RESET;
		tbl_channels = NC_RESET;
		tbl_inv = INV_RESET;
		tbl_row = 0;
		tbl_chan = 0;
		no_coef = known_interval('0, '0, '0, '0, 1'b0);

		add_feed(32'h0000_0000);
		add_known(32'h0001_0000, known_interval(32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0));
		add_feed(32'h8000_0000);
		add_known(32'h7FFF_FFFF, known_interval(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1));
		add_feed(32'h7FFF_FFFF);
		add_known(32'h8000_0000, known_interval(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b1));
		add_write(CFG_INV_SPACING, 32'h0);
		add_feed(32'h1234_5678);
		add_known(32'hFEDC_BA98, known_interval(32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b0));
		add_write(CFG_INV_SPACING, 32'hFFFF_FFFF);
		add_write(CFG_NUM_POINTS, 32'd0);
		add_write(CFG_NUM_CHANNELS, 32'd0);
		add_feed(32'h0000_0001);
		add_feed(32'hFFFF_FFFF);
		add_write(CFG_NUM_POINTS, 32'd1);
		add_feed(32'h0002_0000);
		add_feed(32'hFFFE_0000);
		add_write(CFG_NUM_POINTS, 32'd3);
		add_write(CFG_NUM_CHANNELS, 32'd2);
		add_write(CFG_INV_SPACING, 32'h0000_8000);
		add_feed(32'h0001_0000);
		add_feed(32'hFFFF_0000);
		add_feed(32'h0003_0000);
		add_feed(32'h0000_8000);
		add_feed(32'h0002_0000);
		add_feed(32'hFFF0_0000);
		add_feed(32'h4000_0000);
		add_write(CFG_SPARE, 32'hFFFF_FFFF);
		add_write(CFG_NUM_POINTS, 32'd3);
		add_feed(32'h7FFF_0000);
		add_feed(32'h8001_0000);
		add_feed(32'h0000_0000);
		add_feed(32'h0000_0000);
		add_feed(32'h8000_0000);
		add_feed(32'h7FFF_FFFF);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_WRITE: program_register(directed_rows[i].index, directed_rows[i].data);
				ROW_FEED: feed_sample(directed_rows[i].data, 1'b0, no_coef);
				ROW_FEED_KNOWN: feed_sample(directed_rows[i].data, 1'b1, directed_rows[i].want);
			endcase
		end

		fed = 0;
		while (fed < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: pts_w = $urandom_range(1);
				1: pts_w = $urandom_range(1) ? 32'd4096 : $urandom_range(4097, 8191);
				default: pts_w = $urandom_range(2, 9);
			endcase
			case ($urandom_range(9))
				0: ch_w = 0;
				1: ch_w = $urandom_range(16, 31);
				2: ch_w = $urandom_range(1, 16);
				default: ch_w = $urandom_range(1, 4);
			endcase
			case ($urandom_range(9))
				0: inv = 32'h0;
				1: inv = 32'hFFFF_FFFF;
				2: inv = $urandom;
				3: inv = INV_RESET;
				default: inv = $urandom_range(1, 32'h0004_0000);
			endcase
			program_register(CFG_INV_SPACING, inv);
			program_register(CFG_NUM_POINTS, pts_w);
			program_register(CFG_NUM_CHANNELS, ch_w);
			pts = table_points();
			chans = table_channels();
			if (pts > 9) begin
				items = $urandom_range(20, 60);
			end else begin
				items = pts * chans * $urandom_range(1, 2);
				if ($urandom_range(3) == 0)
					items += $urandom_range(pts * chans - 1);
			end
			mid = ($urandom_range(4) == 0) ? items / 2 : -1;
			for (int k = 0; k < items; k++) begin
				if (k == mid)
					program_register(CFG_INV_SPACING, $urandom);
				if (fed == 200)
					hold_requests++;
				if (fed == 500)
					quiesce();
				calm = fed >= 300 && fed < 450;
				case ($urandom_range(9))
					0: value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					1, 2, 3: value = $urandom;
					default: value = $urandom_range(32'h0008_0000) - 32'h0004_0000;
				endcase
				feed_sample(value, 1'b0, no_coef);
				fed++;
			end
		end

		calm = 1'b0;
		quiesce();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/cscg_pkg.sv
hw/rtl/cscg_mulsc.sv
hw/rtl/cscg_dp.sv
hw/rtl/cscg_ctrl.sv
hw/rtl/cubic_spline_coefficient_generator.sv
test/testbench.sv
